[sv/slbc_pkg.sv]
package slbc_pkg;

  // Width of the error-mode down-counter.
  localparam int TIMER_BITS = 12;
  localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

  // Field and register widths.
  localparam int KIND_W  = 2;
  localparam int COLOR_W = 8;
  localparam int MS_W    = 10;
  localparam int DUR_W   = 12;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 4;

  // The time since the last flash saturates at the top of its range.
  localparam logic [MS_W-1:0] SINCE_MAX = {MS_W{1'b1}};
  localparam logic [COLOR_W-1:0] RED_FULL = 8'd255;

  // Register reset values.
  localparam logic [MS_W-1:0]  FLASH_ON_RST  = 10'd30;
  localparam logic [MS_W-1:0]  COOLDOWN_RST  = 10'd80;
  localparam logic [DUR_W-1:0] DURATION_RST  = 12'd1500;
  localparam logic [MS_W-1:0]  PULSE_RST     = 10'd150;

  // Request kinds; the fourth code has no meaning.
  typedef enum logic [KIND_W-1:0] {
    KIND_TICK  = 2'd0,
    KIND_FLASH = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  // Register indexes, taken from the word address.
  typedef enum logic [1:0] {
    REG_FLASH_ON  = 2'd0,
    REG_COOLDOWN  = 2'd1,
    REG_DURATION  = 2'd2,
    REG_PULSE     = 2'd3
  } reg_idx_t;

endpackage

[sv/slbc_in_if.sv]
interface slbc_in_if
  import slbc_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [COLOR_W-1:0] red_in;
  logic [COLOR_W-1:0] green_in;
  logic [COLOR_W-1:0] blue_in;

  modport source (output valid, kind, red_in, green_in, blue_in, input ready);
  modport sink   (input valid, kind, red_in, green_in, blue_in, output ready);
endinterface

[sv/slbc_out_if.sv]
interface slbc_out_if
  import slbc_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] red_out;
  logic [COLOR_W-1:0] green_out;
  logic [COLOR_W-1:0] blue_out;
  logic               write_strobe;

  modport source (output valid, red_out, green_out, blue_out, write_strobe, input ready);
  modport sink   (input valid, red_out, green_out, blue_out, write_strobe, output ready);
endinterface

[sv/status_led_blink_controller.sv]
// RGB status LED controller. Each request (a one-millisecond tick, a colour
// flash or an error trigger) gives exactly one result with the colour now
// shown and a strobe that marks a new LED write. A request is taken in every
// cycle unless a result waits on a stalled output: it lands in an input
// register, and then the counter updates and compares run in one pass while
// the result is loaded into the output register, which offers it.
// The input register also holds one request while a result waits on a stalled
// output. The user must write timing registers through the APB-style port
// only while the block is idle; the block does not enforce this. Registers
// lie at byte addresses 0, 4, 8 and 12.
module status_led_blink_controller
  import slbc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  slbc_in_if.sink           in_ch,
  slbc_out_if.source        out_ch,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [ADDR_W-1:0] cfg_paddr,
  input  logic [DATA_W-1:0] cfg_pwdata,
  output logic [DATA_W-1:0] cfg_prdata,
  output logic              cfg_pready
);

  // Configuration registers.
  logic [MS_W-1:0]  flash_on_r;
  logic [MS_W-1:0]  cooldown_r;
  logic [DUR_W-1:0] duration_r;
  logic [MS_W-1:0]  pulse_r;
  logic             cfg_wr;
  reg_idx_t         cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flash_on_r <= FLASH_ON_RST;
      cooldown_r <= COOLDOWN_RST;
      duration_r <= DURATION_RST;
      pulse_r    <= PULSE_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_FLASH_ON: flash_on_r <= cfg_pwdata[MS_W-1:0];
        REG_COOLDOWN: cooldown_r <= cfg_pwdata[MS_W-1:0];
        REG_DURATION: duration_r <= cfg_pwdata[DUR_W-1:0];
        REG_PULSE:    pulse_r    <= cfg_pwdata[MS_W-1:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (cfg_idx)
      REG_FLASH_ON: cfg_prdata = DATA_W'(flash_on_r);
      REG_COOLDOWN: cfg_prdata = DATA_W'(cooldown_r);
      REG_DURATION: cfg_prdata = DATA_W'(duration_r);
      REG_PULSE:    cfg_prdata = DATA_W'(pulse_r);
      default:      cfg_prdata = '0;
    endcase
  end

  // Input register.
  logic               s1_valid_r;
  logic [KIND_W-1:0]  s1_kind_r;
  logic [COLOR_W-1:0] s1_red_r;
  logic [COLOR_W-1:0] s1_green_r;
  logic [COLOR_W-1:0] s1_blue_r;

  // Output register.
  logic               out_valid_r;
  logic [COLOR_W-1:0] out_red_r;
  logic [COLOR_W-1:0] out_green_r;
  logic [COLOR_W-1:0] out_blue_r;
  logic               out_wstrb_r;

  logic advance;

  assign advance     = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_kind_r  <= in_ch.kind;
      s1_red_r   <= in_ch.red_in;
      s1_green_r <= in_ch.green_in;
      s1_blue_r  <= in_ch.blue_in;
    end
  end

  // Controller state.
  logic [COLOR_W-1:0]    red_r, green_r, blue_r;
  logic [MS_W-1:0]       flash_remaining_r;
  logic [MS_W-1:0]       since_flash_r;
  logic                  flash_active_r;
  logic [TIMER_BITS-1:0] error_remaining_r;
  logic [MS_W-1:0]       toggle_remaining_r;
  logic                  error_lit_r;

  logic [COLOR_W-1:0]    red_nxt, green_nxt, blue_nxt;
  logic [MS_W-1:0]       flash_remaining_nxt;
  logic [MS_W-1:0]       since_flash_nxt;
  logic                  flash_active_nxt;
  logic [TIMER_BITS-1:0] error_remaining_nxt;
  logic [MS_W-1:0]       toggle_remaining_nxt;
  logic                  error_lit_nxt;
  logic                  wrote;
  logic [TIMER_BITS-1:0] error_load;

  // The error duration is clipped to the width of the error counter.
  assign error_load = (32'(duration_r) > 32'(TIMER_MAX)) ? TIMER_MAX
                                                         : TIMER_BITS'(duration_r);

  // Next state and result for the request in the input register.
  always_comb begin
    red_nxt              = red_r;
    green_nxt            = green_r;
    blue_nxt             = blue_r;
    flash_remaining_nxt  = flash_remaining_r;
    since_flash_nxt      = since_flash_r;
    flash_active_nxt     = flash_active_r;
    error_remaining_nxt  = error_remaining_r;
    toggle_remaining_nxt = toggle_remaining_r;
    error_lit_nxt        = error_lit_r;
    wrote                = 1'b0;
    case (s1_kind_r)
      KIND_TICK: begin
        // Saturating counters move first, then the LED follows them.
        flash_remaining_nxt  = (flash_remaining_r != '0) ? flash_remaining_r - 1'b1 : '0;
        error_remaining_nxt  = (error_remaining_r != '0) ? error_remaining_r - 1'b1 : '0;
        toggle_remaining_nxt = (toggle_remaining_r != '0) ? toggle_remaining_r - 1'b1 : '0;
        if (since_flash_r != SINCE_MAX) begin
          since_flash_nxt = since_flash_r + 1'b1;
        end
        if (error_remaining_nxt != '0) begin
          if (toggle_remaining_nxt == '0) begin
            error_lit_nxt        = !error_lit_r;
            red_nxt              = error_lit_r ? '0 : RED_FULL;
            green_nxt            = '0;
            blue_nxt             = '0;
            toggle_remaining_nxt = pulse_r;
            wrote                = 1'b1;
          end
        end else begin
          if (error_lit_r) begin
            red_nxt       = '0;
            green_nxt     = '0;
            blue_nxt      = '0;
            error_lit_nxt = 1'b0;
            wrote         = 1'b1;
          end
          if (flash_active_r && flash_remaining_nxt == '0) begin
            red_nxt          = '0;
            green_nxt        = '0;
            blue_nxt         = '0;
            flash_active_nxt = 1'b0;
            wrote            = 1'b1;
          end
        end
      end
      KIND_FLASH: begin
        // A flash is refused in error mode and during the cooldown.
        if (error_remaining_r == '0 && since_flash_r >= cooldown_r) begin
          red_nxt             = s1_red_r;
          green_nxt           = s1_green_r;
          blue_nxt            = s1_blue_r;
          flash_remaining_nxt = flash_on_r;
          since_flash_nxt     = '0;
          flash_active_nxt    = 1'b1;
          wrote               = 1'b1;
        end
      end
      KIND_ERROR: begin
        error_remaining_nxt = error_load;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      red_r              <= '0;
      green_r            <= '0;
      blue_r             <= '0;
      flash_remaining_r  <= '0;
      since_flash_r      <= '0;
      flash_active_r     <= 1'b0;
      error_remaining_r  <= '0;
      toggle_remaining_r <= '0;
      error_lit_r        <= 1'b0;
    end else if (advance) begin
      red_r              <= red_nxt;
      green_r            <= green_nxt;
      blue_r             <= blue_nxt;
      flash_remaining_r  <= flash_remaining_nxt;
      since_flash_r      <= since_flash_nxt;
      flash_active_r     <= flash_active_nxt;
      error_remaining_r  <= error_remaining_nxt;
      toggle_remaining_r <= toggle_remaining_nxt;
      error_lit_r        <= error_lit_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_red_r   <= red_nxt;
      out_green_r <= green_nxt;
      out_blue_r  <= blue_nxt;
      out_wstrb_r <= wrote;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.red_out      = out_red_r;
  assign out_ch.green_out    = out_green_r;
  assign out_ch.blue_out     = out_blue_r;
  assign out_ch.write_strobe = out_wstrb_r;

`ifndef SYNTHESIS
  // A request held in the input register stays put until it is processed.
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !advance |=> s1_valid_r && $stable(s1_kind_r))
    else $error("input register lost a waiting request");

  // An error trigger never writes the LED.
  a_err_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    advance && s1_kind_r == KIND_ERROR |=> !out_wstrb_r)
    else $error("error trigger produced a write strobe");

  // A flash during error mode is refused.
  a_flash_refused: assert property (@(posedge clk) disable iff (!rst_n)
    advance && s1_kind_r == KIND_FLASH && error_remaining_r != '0 |=> !out_wstrb_r)
    else $error("flash accepted during error mode");

  // An accepted flash restarts the cooldown and marks the flash active.
  a_flash_start: assert property (@(posedge clk) disable iff (!rst_n)
    advance && s1_kind_r == KIND_FLASH && wrote |=> since_flash_r == '0 && flash_active_r)
    else $error("accepted flash did not start its timers");
`endif

endmodule
